// ===== rtl/sahta_pkg.sv =====
// Shared types and constants for the set-associative hash table.
// Used by every module of the block but sahta_ram; depends on nothing.
package sahta_pkg;

    localparam int DEF_MAX_SETS = 1024;
    localparam int DEF_WAYS     = 4;

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 32;
    localparam int DEPTH_W = 8;
    localparam int BOUND_W = 2;
    localparam int MOVE_W  = 32;
    localparam int GEN_W   = 16;
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 11;
    localparam int AGE_SHIFT = 10;   // age weight of 1024

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic signed [31:0] EMPTY_SCORE = 32'sd1000000000;
    localparam logic signed [31:0] START_SCORE = -32'sd1000000000;

    localparam logic [CMD_W-1:0] CMD_PROBE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_PROBE,
        OP_STORE,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [SCORE_W-1:0]        score_bits;
        logic signed [DEPTH_W-1:0] depth;
        logic [BOUND_W-1:0]        bound_kind;
        logic [MOVE_W-1:0]         move_code;
        logic [GEN_W-1:0]          generation;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        op_t    op;
        entry_t entry;
    } item_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_out_t;

endpackage

// ===== rtl/sahta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module sahta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sahta_front.sv =====
// Front end: accepts input words, decodes the command and queues them.
// Depends on sahta_pkg.
module sahta_front
    import sahta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [159:0]       s_axis_tdata,
    input  logic [CMD_W-1:0]   s_axis_tuser,
    input  logic               hold,
    output q_out_t             q_out,
    input  logic               q_pop
);

    item_t      ent_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    item_t      in_item;
    logic       push;

    // Unpack the word fields and decode the command into an operation
    always_comb
    begin
        in_item.entry.key        = s_axis_tdata[63:0];
        in_item.entry.score_bits = s_axis_tdata[95:64];
        in_item.entry.depth      = s_axis_tdata[103:96];
        in_item.entry.bound_kind = s_axis_tdata[105:104];
        in_item.entry.move_code  = s_axis_tdata[137:106];
        in_item.entry.generation = s_axis_tdata[153:138];
        case (s_axis_tuser)
            CMD_PROBE: in_item.op = OP_PROBE;
            CMD_STORE: in_item.op = OP_STORE;
            CMD_CLEAR: in_item.op = OP_CLEAR;
            default:   in_item.op = OP_NOP;
        endcase
    end

    assign s_axis_tready = (cnt_reg != 2'd2) && !hold;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_out.valid   = (cnt_reg != 2'd0);
    assign q_out.item    = ent_reg[rptr_reg];

    // Advance the two-entry queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/sahta_mod.sv =====
// Bit-serial remainder unit: key modulo set count, one key bit per cycle.
// Depends on sahta_pkg.
module sahta_mod
    import sahta_pkg::*;
#(
    parameter int NW = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] dividend,
    input  logic [NW-1:0]    divisor,
    output logic             done,
    output logic [NW-1:0]    remainder
);

    localparam int CW = $clog2(KEY_W);

    logic [KEY_W-1:0]         shift_reg;
    logic [NW-1:0]            rem_reg;
    logic [NW-1:0]            div_reg;
    logic [CW-1:0]            cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [NW:0]              trial;
    logic [NW:0]              rem_next;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, shift_reg[KEY_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = trial - {1'b0, div_reg};
        end
        else
        begin
            rem_next = trial;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(KEY_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift the key through
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[KEY_W-2:0], 1'b0};
            rem_reg   <= rem_next[NW-1:0];
        end
    end

endmodule

// ===== rtl/sahta_back.sv =====
// Back end: reduces the key to a set, walks the ways, writes and reports.
// Depends on sahta_pkg; drives sahta_mod and the slot RAM from the top.
module sahta_back
    import sahta_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int WAYS     = DEF_WAYS,
    parameter int NW       = $clog2(MAX_SETS + 1),
    parameter int AW       = (MAX_SETS * WAYS > 1) ? $clog2(MAX_SETS * WAYS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [CFG_W-1:0]   cfg_data,
    input  q_out_t             q_out,
    output logic               q_pop,
    output logic               hold,
    output logic               mod_start,
    output logic [KEY_W-1:0]   mod_key,
    output logic [NW-1:0]      mod_div,
    input  logic               mod_done,
    input  logic [NW-1:0]      mod_rem,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output entry_t             ram_wdata,
    output logic [AW-1:0]      ram_raddr,
    input  entry_t             ram_rdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [95:0]        m_axis_tdata,
    output logic               m_axis_tuser
);

    localparam int SW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
    localparam int DEPTH = MAX_SETS * WAYS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_RD,
        S_EV,
        S_WR,
        S_OUT,
        S_CLR
    } state_t;

    state_t             state_reg;
    logic               init_reg;
    logic [CFG_W-1:0]   set_count_reg;
    item_t              item_reg;
    logic [SW-1:0]      set_reg;
    logic [WW-1:0]      way_reg;
    logic [WW-1:0]      pick_reg;
    logic               found_reg;
    logic signed [31:0] best_reg;
    entry_t             hit_reg;
    logic [AW-1:0]      clr_reg;
    logic               out_valid_reg;
    logic               out_hit_reg;
    entry_t             out_ent_reg;

    logic [CW-1:0]      cnt_ext;
    logic [AW-1:0]      base;
    logic               match;
    logic signed [16:0] age_d;
    logic signed [8:0]  dep_d;
    logic signed [31:0] score;
    logic               last_way;

    // Clamp the set count into one to the table size
    always_comb
    begin
        cnt_ext = CW'(set_count_reg);
        if (cnt_ext == '0)
        begin
            mod_div = NW'(1);
        end
        else if (cnt_ext > CW'(MAX_SETS))
        begin
            mod_div = NW'(MAX_SETS);
        end
        else
        begin
            mod_div = cnt_ext[NW-1:0];
        end
    end

    // Score the way that the RAM returns
    always_comb
    begin
        match = (ram_rdata.key == item_reg.entry.key);
        age_d = $signed({1'b0, item_reg.entry.generation})
              - $signed({1'b0, ram_rdata.generation});
        dep_d = $signed({item_reg.entry.depth[DEPTH_W-1], item_reg.entry.depth})
              - $signed({ram_rdata.depth[DEPTH_W-1], ram_rdata.depth});
        if (ram_rdata.key == '0)
        begin
            score = EMPTY_SCORE;
        end
        else
        begin
            score = $signed({{5{age_d[16]}}, age_d, {AGE_SHIFT{1'b0}}})
                  + $signed({{23{dep_d[8]}}, dep_d});
        end
    end

    assign base      = AW'(set_reg) * AW'(WAYS);
    assign last_way  = (way_reg == WW'(WAYS - 1));
    assign hold      = init_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_out.valid && !init_reg;
    assign mod_start = q_pop && (q_out.item.op == OP_PROBE || q_out.item.op == OP_STORE);
    assign mod_key   = q_out.item.entry.key;

    // Drive the slot RAM
    always_comb
    begin
        ram_raddr = base + AW'(way_reg);
        ram_we    = 1'b0;
        ram_waddr = base + AW'(pick_reg);
        ram_wdata = item_reg.entry;
        if (state_reg == S_WR)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {6'd0, out_ent_reg.generation, out_ent_reg.move_code,
                            out_ent_reg.bound_kind, out_ent_reg.depth,
                            out_ent_reg.score_bits};

    // Sequencer, configuration and output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b1;
            set_count_reg <= CFG_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            way_reg       <= '0;
            pick_reg      <= '0;
            found_reg     <= 1'b0;
            item_reg      <= '0;
            set_reg       <= '0;
            best_reg      <= START_SCORE;
            hit_reg       <= '0;
            out_ent_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                set_count_reg <= cfg_data;
            end
            // Drop the output word once taken, unless a new one loads now
            if (out_valid_reg && m_axis_tready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        item_reg  <= q_out.item;
                        way_reg   <= '0;
                        pick_reg  <= '0;
                        found_reg <= 1'b0;
                        best_reg  <= START_SCORE;
                        clr_reg   <= '0;
                        case (q_out.item.op)
                            OP_PROBE, OP_STORE: state_reg <= S_MOD;
                            OP_CLEAR:           state_reg <= S_CLR;
                            default:            state_reg <= S_OUT;
                        endcase
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        set_reg   <= mod_rem[SW-1:0];
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EV;
                end
                S_EV:
                begin
                    if (!found_reg)
                    begin
                        if (match)
                        begin
                            found_reg <= 1'b1;
                            pick_reg  <= way_reg;
                            hit_reg   <= ram_rdata;
                        end
                        else if (score > best_reg)
                        begin
                            best_reg <= score;
                            pick_reg <= way_reg;
                        end
                    end
                    if (last_way)
                    begin
                        state_reg <= (item_reg.op == OP_STORE) ? S_WR : S_OUT;
                    end
                    else
                    begin
                        way_reg   <= way_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_WR:
                begin
                    state_reg <= S_OUT;
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DEPTH - 1))
                    begin
                        init_reg  <= 1'b0;
                        state_reg <= init_reg ? S_IDLE : S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        if (item_reg.op == OP_PROBE && found_reg)
                        begin
                            out_hit_reg <= 1'b1;
                            out_ent_reg <= hit_reg;
                        end
                        else
                        begin
                            out_hit_reg <= 1'b0;
                            out_ent_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/set_assoc_hash_table_age_depth.sv =====
// Top level of the set-associative hash table: front queue, back sequencer,
// remainder unit and slot RAM. Depends on sahta_pkg and all sahta_* modules.
//
// A probe or store leaves the input queue, then reduces the 64-bit key modulo
// the set count with a bit-serial remainder unit, then reads the set's ways one
// at a time through the single RAM read port (a read state and an evaluate
// state per way), writes the chosen way on a store and loads the output
// register, one item at a time. A clear leaves the queue, sweeps every slot,
// one per cycle, and then loads the output. After reset the same sweep runs
// and s_axis_tready stays low throughout it; configuration writes are taken
// throughout. A two-word input queue and the output register let each side
// stall on its own.
module set_assoc_hash_table_age_depth
    import sahta_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int WAYS     = DEF_WAYS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,      // set_count
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // key[63:0], score_bits[95:64], search_depth[103:96], bound_kind[105:104],
    // move_code[137:106], generation[153:138], zero fill above
    input  logic [159:0]     s_axis_tdata,
    input  logic [CMD_W-1:0] s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // out_score_bits[31:0], out_depth[39:32], out_bound_kind[41:40],
    // out_move_code[73:42], out_generation[89:74], zero fill above
    output logic [95:0]      m_axis_tdata,
    output logic             m_axis_tuser   // hit
);

    localparam int NW    = $clog2(MAX_SETS + 1);
    localparam int DEPTH = MAX_SETS * WAYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    q_out_t           q_out;
    logic             q_pop;
    logic             hold;
    logic             mod_start;
    logic [KEY_W-1:0] mod_key;
    logic [NW-1:0]    mod_div;
    logic             mod_done;
    logic [NW-1:0]    mod_rem;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    sahta_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .hold          (hold),
        .q_out         (q_out),
        .q_pop         (q_pop)
    );

    sahta_mod #(.NW(NW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_key),
        .divisor   (mod_div),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    sahta_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sahta_back #(
        .MAX_SETS (MAX_SETS),
        .WAYS     (WAYS),
        .NW       (NW),
        .AW       (AW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .q_out         (q_out),
        .q_pop         (q_pop),
        .hold          (hold),
        .mod_start     (mod_start),
        .mod_key       (mod_key),
        .mod_div       (mod_div),
        .mod_done      (mod_done),
        .mod_rem       (mod_rem),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (entry_t'(ram_rdata)),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/sahta_checker.sv =====
// Port-level checks for the hash table top level, bound to it below.
// Depends on sahta_pkg and set_assoc_hash_table_age_depth.
module sahta_checker
    import sahta_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_ready,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [95:0]      m_axis_tdata,
    input logic             m_axis_tuser
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // A miss or non-probe word carries zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss word with nonzero fields");

    // Configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

    // The clearing pass after reset blocks input
    a_init_block: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

endmodule

bind set_assoc_hash_table_age_depth sahta_checker u_sahta_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ready     (cfg_ready),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/set_assoc_hash_table_age_depth_tb.sv =====
`timescale 1ns / 100ps
// Testbench for set_assoc_hash_table_age_depth: directed and random command
// traffic checked against a behavioral table model. Depends on sahta_pkg.
module set_assoc_hash_table_age_depth_tb;
    import sahta_pkg::*;

    localparam int N_SETS   = 1024;
    localparam int N_WAYS   = 4;
    localparam int N_SLOTS  = N_SETS * N_WAYS;
    localparam int STALL_LONG = 400;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        entry_t           ent;
    } req_t;

    typedef struct packed {
        logic                      hit;
        logic [SCORE_W-1:0]        score_bits;
        logic signed [DEPTH_W-1:0] depth;
        logic [BOUND_W-1:0]        bound_kind;
        logic [MOVE_W-1:0]         move_code;
        logic [GEN_W-1:0]          generation;
    } lookup_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [159:0]     s_axis_tdata;
    logic [CMD_W-1:0] s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [95:0]      m_axis_tdata;
    logic             m_axis_tuser;

    // Shadow table and set count
    logic [KEY_W-1:0] tbl_key [N_SLOTS];
    entry_t           tbl_ent [N_SLOTS];
    int               cur_sets;

    req_t    pending_words[$];
    lookup_t expected_lookups[$];
    int      errors;
    longint  cycle_count;
    bit      rx_hold;
    bit      no_idle;
    bit      in_acc;

    set_assoc_hash_table_age_depth dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void wipe_shadow();
        for (int i = 0; i < N_SLOTS; i++)
        begin
            tbl_key[i] = '0;
            tbl_ent[i] = '0;
        end
    endfunction

    // Apply one command to the shadow table and return its lookup result
    function automatic lookup_t apply_table_cmd(req_t r);
        lookup_t res;
        int      base;
        int      pick;
        int      best;
        int      sc;
        bit      found;
        res = '0;
        base = int'(r.ent.key % longint'(cur_sets)) * N_WAYS;
        if (r.cmd == CMD_PROBE)
        begin
            for (int w = 0; w < N_WAYS; w++)
                if (!res.hit && tbl_key[base+w] == r.ent.key)
                begin
                    res.hit        = 1'b1;
                    res.score_bits = tbl_ent[base+w].score_bits;
                    res.depth      = tbl_ent[base+w].depth;
                    res.bound_kind = tbl_ent[base+w].bound_kind;
                    res.move_code  = tbl_ent[base+w].move_code;
                    res.generation = tbl_ent[base+w].generation;
                end
        end
        else if (r.cmd == CMD_STORE)
        begin
            pick = base;
            found = 0;
            for (int w = 0; w < N_WAYS; w++)
                if (!found && tbl_key[base+w] == r.ent.key)
                begin
                    pick = base + w;
                    found = 1;
                end
            if (!found)
            begin
                best = START_SCORE;
                for (int w = 0; w < N_WAYS; w++)
                begin
                    if (tbl_key[base+w] == '0)
                        sc = EMPTY_SCORE;
                    else
                        sc = (int'(r.ent.generation) - int'(tbl_ent[base+w].generation)) * 1024
                           + (int'(r.ent.depth) - int'(tbl_ent[base+w].depth));
                    if (sc > best)
                    begin
                        best = sc;
                        pick = base + w;
                    end
                end
            end
            tbl_key[pick] = r.ent.key;
            tbl_ent[pick] = r.ent;
        end
        else if (r.cmd == CMD_CLEAR)
            wipe_shadow();
        return res;
    endfunction

    // Record input acceptance at the rising edge
    always @(posedge clk)
    begin
        in_acc <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Drive input words at the falling edge, predicting on acceptance
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_acc)
            begin
                expected_lookups.push_back(apply_table_cmd(pending_words.pop_front()));
            end
            // Hold an offered word until it is taken
            if (!s_axis_tvalid || in_acc)
            begin
                if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 38))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_words[0].cmd;
                    s_axis_tdata  <= {6'd0, pending_words[0].ent.generation,
                                      pending_words[0].ent.move_code,
                                      pending_words[0].ent.bound_kind,
                                      pending_words[0].ent.depth,
                                      pending_words[0].ent.score_bits,
                                      pending_words[0].ent.key};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 38);
        end
    end

    // Check result words at the rising edge
    always @(posedge clk)
    begin
        lookup_t got;
        lookup_t exp_l;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32],
                    m_axis_tdata[41:40], m_axis_tdata[73:42], m_axis_tdata[89:74]};
            if (expected_lookups.size() == 0)
            begin
                $display("%0t: unexpected word, actual %p", $time, got);
                errors++;
            end
            else
            begin
                exp_l = expected_lookups.pop_front();
                if (got !== exp_l)
                begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, exp_l, got);
                    errors++;
                end
            end
        end
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_lookups.size() > 0)
            @(posedge clk);
        repeat (5000) @(posedge clk);
    endtask

    task automatic write_set_count(int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_sets = (value == 0) ? 1 : (value > N_SETS ? N_SETS : value);
    endtask

    function automatic req_t make_word(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k);
        req_t r;
        r.cmd = c;
        r.ent.key = k;
        r.ent.score_bits = $urandom;
        r.ent.depth = DEPTH_W'($urandom);
        r.ent.bound_kind = BOUND_W'($urandom_range(2));
        r.ent.move_code = $urandom;
        r.ent.generation = GEN_W'($urandom);
        return r;
    endfunction

    // Keys drawn from a small pool so that sets fill and replace
    function automatic logic [KEY_W-1:0] pick_key(int pool);
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return '0;
            default: return KEY_W'($urandom_range(pool)) * 64'h1_0000_0401 + 1;
        endcase
    endfunction

    task automatic run_phase(int n, int pool);
        req_t r;
        int   sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            r = make_word(sel < 45 ? CMD_PROBE : (sel < 97 ? CMD_STORE :
                          (sel < 99 ? CMD_CLEAR : CMD_W'(OP_NOP))), pick_key(pool));
            if ($urandom_range(3) == 0)
                r.ent.generation = GEN_W'($urandom_range(3));
            pending_words.push_back(r);
        end
    endtask

    initial
    begin
        req_t r;
        errors = 0;
        cycle_count = 0;
        rx_hold = 0;
        no_idle = 0;
        in_acc = 0;
        cur_sets = N_SETS;
        wipe_shadow();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_PROBE;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, each command, zero key, replacement by score
        write_set_count(1);
        r = make_word(CMD_PROBE, '0);                 pending_words.push_back(r);
        r = make_word(CMD_PROBE, '1);                 pending_words.push_back(r);
        r = make_word(CMD_STORE, '1);
        r.ent.score_bits = '1; r.ent.depth = 8'sd127; r.ent.bound_kind = 2'd2;
        r.ent.move_code = '1; r.ent.generation = '1; pending_words.push_back(r);
        for (int i = 1; i <= 4; i++)
        begin
            r = make_word(CMD_STORE, KEY_W'(i));
            r.ent.depth = (i == 2) ? -8'sd128 : 8'sd0;
            r.ent.generation = '0;
            pending_words.push_back(r);
        end
        r = make_word(CMD_STORE, 64'd9); r.ent.generation = 16'd1; pending_words.push_back(r);
        for (int i = 0; i <= 9; i++)
            pending_words.push_back(make_word(CMD_PROBE, KEY_W'(i)));
        pending_words.push_back(make_word(CMD_PROBE, '1));
        pending_words.push_back(make_word(CMD_W'(OP_NOP), 64'd5));
        pending_words.push_back(make_word(CMD_CLEAR, 64'd0));
        pending_words.push_back(make_word(CMD_PROBE, '1));
        wait_drained();

        // Random phases over several set counts
        write_set_count(0);
        run_phase(150, 12);
        wait_drained();
        write_set_count(3);
        no_idle = 1;
        run_phase(200, 40);
        wait_drained();
        no_idle = 0;
        write_set_count(2047);
        run_phase(200, 3000);
        // Hold the receiver so the input queue backs up
        rx_hold = 1;
        repeat (STALL_LONG) @(posedge clk);
        rx_hold = 0;
        wait_drained();
        write_set_count(1024);
        run_phase(350, 5000);
        wait_drained();
        write_set_count(7);
        run_phase(400, 60);
        wait_drained();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== set_assoc_hash_table_age_depth.f =====
rtl/sahta_pkg.sv
rtl/sahta_ram.sv
rtl/sahta_front.sv
rtl/sahta_mod.sv
rtl/sahta_back.sv
rtl/set_assoc_hash_table_age_depth.sv
rtl/sahta_checker.sv
verif/set_assoc_hash_table_age_depth_tb.sv
